>>> rtl/core/isss_pkg.sv
`timescale 1ns / 1ps
// Package for the indexed sequence store: sizes, operation and status codes,
// transaction structs and the per-cell command. No dependencies.
package isss_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int DATA_W      = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Priority encoder grouping for the find and remove-by-value search.
    localparam int GRP_SIZE = 16;
    localparam int GRP_W    = $clog2(GRP_SIZE);
    localparam int NUM_GRPS = (MAX_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;

    localparam logic [2:0] OP_APPEND     = 3'd0;
    localparam logic [2:0] OP_INSERT     = 3'd1;
    localparam logic [2:0] OP_GET        = 3'd2;
    localparam logic [2:0] OP_SET        = 3'd3;
    localparam logic [2:0] OP_FIND       = 3'd4;
    localparam logic [2:0] OP_REMOVE_AT  = 3'd5;
    localparam logic [2:0] OP_REMOVE_VAL = 3'd6;
    localparam logic [2:0] OP_CLEAR      = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Commands broadcast to every cell of the chain.
    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_CMP    = 3'd1;
    localparam logic [2:0] CMD_INSERT = 3'd2;
    localparam logic [2:0] CMD_WRITE  = 3'd3;
    localparam logic [2:0] CMD_REMOVE = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic [8:0]         position_in;
        logic signed [31:0] value_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic [7:0]         position_out;
        logic               found;
        logic [1:0]         status;
        logic [8:0]         count_out;
    } out_item_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] value;
        logic [CNT_W-1:0]  count;
    } cell_cmd_t;

endpackage

>>> rtl/core/isss_cell.sv
`timescale 1ns / 1ps
// One storage cell of the sequence chain: holds one element, shifts with its
// neighbors and compares against a broadcast value. Depends on isss_pkg.
module isss_cell
    import isss_pkg::*;
(
    input  logic              clk,
    input  logic [IDX_W-1:0]  my_index,
    input  cell_cmd_t         cmd,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data,
    output logic              match
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              match_reg;
    logic              match_next;

    always_comb
    begin
        data_next  = data_reg;
        match_next = match_reg;
        unique case (cmd.kind)
            CMD_CMP:
            begin
                match_next = (data_reg == cmd.value)
                             && (CNT_W'(my_index) < cmd.count);
            end
            CMD_INSERT:
            begin
                if (my_index == cmd.index)
                begin
                    data_next = cmd.value;
                end
                else if (my_index > cmd.index)
                begin
                    data_next = left_data;
                end
            end
            CMD_WRITE:
            begin
                if (my_index == cmd.index)
                begin
                    data_next = cmd.value;
                end
            end
            CMD_REMOVE:
            begin
                if (my_index >= cmd.index)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

>>> rtl/core/isss_prio_enc.sv
`timescale 1ns / 1ps
// Two-stage registered priority encoder over the match flags of the chain.
// Depends on isss_pkg.
module isss_prio_enc
    import isss_pkg::*;
(
    input  logic                   clk,
    input  logic [MAX_ENTRIES-1:0] flags,
    output logic                   hit,
    output logic [IDX_W-1:0]       hit_index
);

    localparam int PAD = NUM_GRPS * GRP_SIZE;

    logic [PAD-1:0]   flags_pad;
    logic             grp_any_reg  [NUM_GRPS];
    logic [GRP_W-1:0] grp_idx_reg  [NUM_GRPS];
    logic             grp_any_next [NUM_GRPS];
    logic [GRP_W-1:0] grp_idx_next [NUM_GRPS];
    logic             hit_reg;
    logic             hit_next;
    logic [IDX_W-1:0] index_reg;
    logic [IDX_W-1:0] index_next;

    assign flags_pad = PAD'(flags);

    // First stage: lowest set flag inside each group.
    always_comb
    begin
        for (int g = 0; g < NUM_GRPS; g++)
        begin
            grp_any_next[g] = 1'b0;
            grp_idx_next[g] = '0;
            for (int k = GRP_SIZE - 1; k >= 0; k--)
            begin
                if (flags_pad[g * GRP_SIZE + k])
                begin
                    grp_any_next[g] = 1'b1;
                    grp_idx_next[g] = GRP_W'(k);
                end
            end
        end
    end

    // Second stage: lowest group that has a hit.
    always_comb
    begin
        hit_next   = 1'b0;
        index_next = '0;
        for (int g = NUM_GRPS - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                hit_next   = 1'b1;
                index_next = IDX_W'(g * GRP_SIZE) + IDX_W'(grp_idx_reg[g]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NUM_GRPS; g++)
        begin
            grp_any_reg[g] <= grp_any_next[g];
            grp_idx_reg[g] <= grp_idx_next[g];
        end
        hit_reg   <= hit_next;
        index_reg <= index_next;
    end

    assign hit       = hit_reg;
    assign hit_index = index_reg;

endmodule

>>> rtl/core/indexed_sequence_store_unit.sv
`timescale 1ns / 1ps
// Top level of the indexed sequence store: controller, cell chain and search
// encoder. Depends on isss_pkg, isss_cell and isss_prio_enc.
//
// Usage: a transaction is offered on item with start high; it is taken at the
// rising edge where start is high and busy is low. Each transaction yields
// exactly one result on result, qualified by result_valid for a single cycle.
// The receiver cannot stall, so it must capture result whenever result_valid
// is high.
//
// The elements live in a row of cells, one element per cell. Inserts shift
// the cells above the insert point up by one from their lower neighbor, and
// removals shift them down from their upper neighbor, all at once.
//
// Sequencing: append, insert, get, set, remove at and clear go from acceptance
// to the result strobe through a capture step and an execute step.
// Find and remove value take a compare step in every cell, then the
// registered priority encoder states S_ENC1 and S_ENC2, then execute. A new
// transaction may be accepted in the same cycle that the previous result is
// strobed; no new transaction is taken while busy is high.
//
// Reset clears the element count, the controller and the result strobe. Cell
// contents are not reset; only cells below the count are ever read.
module indexed_sequence_store_unit
    import isss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  item,
    output logic      busy,
    output logic      result_valid,
    output out_item_t result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_ENC1 = 3'd2;
    localparam logic [2:0] S_ENC2 = 3'd3;
    localparam logic [2:0] S_EXEC = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    in_item_t         item_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             strobe_reg;
    logic             strobe_next;
    out_item_t        result_reg;
    out_item_t        result_next;

    cell_cmd_t              cmd;
    logic [DATA_W-1:0]      cell_data [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cell_match;
    logic                   hit;
    logic [IDX_W-1:0]       hit_index;

    logic              accept;
    logic              pos_in_range;
    logic              full;
    logic [IDX_W-1:0]  ins_index;
    logic [IDX_W-1:0]  rd_index;
    logic [DATA_W-1:0] rd_data;
    logic [DATA_W-1:0] wr_value;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // The cell chain. Cell zero sees zero on its left; the top cell sees its
    // own value on its right, which fills the vacated slot on a removal.
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;
        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_left
            assign left_d = cell_data[i-1];
        end
        if (i == MAX_ENTRIES - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_right
            assign right_d = cell_data[i+1];
        end
        isss_cell u_cell (
            .clk        (clk),
            .my_index   (IDX_W'(i)),
            .cmd        (cmd),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .match      (cell_match[i])
        );
    end

    isss_prio_enc u_enc (
        .clk       (clk),
        .flags     (cell_match),
        .hit       (hit),
        .hit_index (hit_index)
    );

    // Decode of the captured transaction.
    assign wr_value     = DATA_W'(item_reg.value_in);
    assign pos_in_range = (32'(item_reg.position_in) < 32'(count_reg));
    assign full         = (count_reg == CNT_W'(MAX_ENTRIES));
    assign ins_index    = ((item_reg.op == OP_APPEND) || !pos_in_range)
                          ? IDX_W'(count_reg) : IDX_W'(item_reg.position_in);
    assign rd_index     = (item_reg.op == OP_REMOVE_VAL)
                          ? hit_index : IDX_W'(item_reg.position_in);
    assign rd_data      = cell_data[rd_index];

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        strobe_next = 1'b0;
        result_next = result_reg;

        cmd.kind  = CMD_NONE;
        cmd.index = '0;
        cmd.value = wr_value;
        cmd.count = count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((item.op == OP_FIND) || (item.op == OP_REMOVE_VAL))
                    begin
                        state_next = S_CMP;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_CMP:
            begin
                cmd.kind   = CMD_CMP;
                state_next = S_ENC1;
            end
            S_ENC1:
            begin
                state_next = S_ENC2;
            end
            S_ENC2:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next               = S_IDLE;
                strobe_next              = 1'b1;
                result_next.value_out    = '0;
                result_next.position_out = '0;
                result_next.found        = 1'b0;
                result_next.status       = ST_OK;

                unique case (item_reg.op)
                    OP_APPEND, OP_INSERT:
                    begin
                        if (full)
                        begin
                            result_next.status = ST_FULL;
                        end
                        else
                        begin
                            cmd.kind   = CMD_INSERT;
                            cmd.index  = ins_index;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    OP_GET:
                    begin
                        if (pos_in_range)
                        begin
                            result_next.value_out = 32'(signed'(rd_data));
                        end
                        else
                        begin
                            result_next.status = ST_RANGE;
                        end
                    end
                    OP_SET:
                    begin
                        if (pos_in_range)
                        begin
                            cmd.kind  = CMD_WRITE;
                            cmd.index = IDX_W'(item_reg.position_in);
                        end
                        else
                        begin
                            result_next.status = ST_RANGE;
                        end
                    end
                    OP_FIND:
                    begin
                        if (hit)
                        begin
                            result_next.found        = 1'b1;
                            result_next.position_out = 8'(hit_index);
                        end
                    end
                    OP_REMOVE_AT:
                    begin
                        if (pos_in_range)
                        begin
                            result_next.value_out = 32'(signed'(rd_data));
                            cmd.kind   = CMD_REMOVE;
                            cmd.index  = rd_index;
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            result_next.status = ST_RANGE;
                        end
                    end
                    OP_REMOVE_VAL:
                    begin
                        if (hit)
                        begin
                            result_next.found        = 1'b1;
                            result_next.position_out = 8'(hit_index);
                            result_next.value_out    = 32'(signed'(rd_data));
                            cmd.kind   = CMD_REMOVE;
                            cmd.index  = rd_index;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    OP_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        count_next = count_reg;
                    end
                endcase
                result_next.count_out = 9'(count_next);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        result_reg <= result_next;
    end

    assign result_valid = strobe_reg;
    assign result       = result_reg;

    // A result strobe always follows an execute cycle.
    a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == S_EXEC))
        else $error("result strobe without execute cycle");

    // The element count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("element count above capacity");

    // An accepted transaction makes the unit busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // A full report leaves the count at capacity.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status == ST_FULL))
            |-> (count_reg == CNT_W'(MAX_ENTRIES)))
        else $error("full status with count below capacity");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for indexed_sequence_store_unit: directed and random
// transactions checked against an in-bench predictor. Depends on isss_pkg and the DUT.
module testbench;
    import isss_pkg::*;

    // The run is about 1070 transactions plus idle gaps from the sender. The
    // limit below is many times what the slowest correct run takes.
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [31:0] MARKER = 32'h5A5A_A5A5;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_item_t  item = '0;
    logic      busy;
    logic      result_valid;
    out_item_t result;

    indexed_sequence_store_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    // Transactions waiting to be offered, and results owed by the block in
    // the order their transactions were taken.
    in_item_t  pending_items[$];
    out_item_t expected_results[$];
    out_item_t oldest;

    // Our own copy of the store: the element words and how many are live.
    logic [31:0] store_words[MAX_ENTRIES];
    int          store_count = 0;

    int   error_count = 0;
    int   cycle_count = 0;
    int   sent_items = 0;
    int   total_items = 0;
    logic took = 1'b0;

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Index of the first live element equal to the word, or -1.
    function automatic int locate_value(logic [31:0] word);
        int i;
        for (i = 0; i < store_count; i++)
            if (store_words[i] == word)
                return i;
        return -1;
    endfunction

    // Close the gap left by a removed element.
    function automatic void drop_slot(int slot);
        int i;
        for (i = slot; i + 1 < store_count; i++)
            store_words[i] = store_words[i + 1];
        store_count--;
    endfunction

    // Applies one transaction to the local store and returns the result the
    // block must report for it.
    function automatic out_item_t apply_operation(in_item_t t);
        out_item_t r;
        int        slot;
        int        i;
        r = '0;
        case (t.op)
            OP_APPEND, OP_INSERT:
            begin
                if (store_count >= MAX_ENTRIES)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // Inserting at or past the end behaves like an append.
                    if (t.op == OP_APPEND || int'(t.position_in) >= store_count)
                        slot = store_count;
                    else
                        slot = int'(t.position_in);
                    for (i = store_count; i > slot; i--)
                        store_words[i] = store_words[i - 1];
                    store_words[slot] = t.value_in;
                    store_count++;
                end
            end
            OP_GET:
            begin
                if (int'(t.position_in) >= store_count)
                    r.status = ST_RANGE;
                else
                    r.value_out = store_words[t.position_in[IDX_W-1:0]];
            end
            OP_SET:
            begin
                if (int'(t.position_in) >= store_count)
                    r.status = ST_RANGE;
                else
                    store_words[t.position_in[IDX_W-1:0]] = t.value_in;
            end
            OP_FIND, OP_REMOVE_VAL:
            begin
                slot = locate_value(t.value_in);
                if (slot >= 0)
                begin
                    r.found = 1'b1;
                    r.position_out = 8'(slot);
                    if (t.op == OP_REMOVE_VAL)
                    begin
                        r.value_out = store_words[slot];
                        drop_slot(slot);
                    end
                end
            end
            OP_REMOVE_AT:
            begin
                if (int'(t.position_in) >= store_count)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    r.value_out = store_words[t.position_in[IDX_W-1:0]];
                    drop_slot(int'(t.position_in));
                end
            end
            default:
            begin
                store_count = 0;
            end
        endcase
        r.count_out = 9'(store_count);
        return r;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic push_item(logic [2:0] op, int pos, logic [31:0] word);
        in_item_t t;
        t.op = op;
        t.position_in = 9'(pos);
        t.value_in = word;
        pending_items.push_back(t);
    endtask

    // Values lean toward a small pool so that find and remove by value hit
    // often, with the extremes and fully random words mixed in.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3, 4, 5: return 32'($urandom_range(7)) - 32'd3;
            default: return $urandom();
        endcase
    endfunction

    // Mixed operations with positions mostly inside the live range. The
    // running size is only an estimate; it steers positions and nothing else.
    task automatic build_mixed(int n, inout int est);
        int          k;
        int          pick;
        int          pos;
        int          r;
        logic [31:0] word;
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            word = pick_value();
            r = $urandom_range(9);
            if (r == 0)
                pos = $urandom_range(511);
            else if (r == 1)
                pos = est;
            else
                pos = (est > 0) ? $urandom_range(est - 1) : 0;
            if (pick < 22)
            begin
                push_item(OP_APPEND, $urandom_range(511), word);
                if (est < MAX_ENTRIES)
                    est++;
            end
            else if (pick < 42)
            begin
                push_item(OP_INSERT, (r == 2) ? 0 : pos, word);
                if (est < MAX_ENTRIES)
                    est++;
            end
            else if (pick < 56)
            begin
                push_item(OP_GET, pos, word);
            end
            else if (pick < 66)
            begin
                push_item(OP_SET, pos, word);
            end
            else if (pick < 77)
            begin
                push_item(OP_FIND, pos, word);
            end
            else if (pick < 88)
            begin
                push_item(OP_REMOVE_AT, pos, word);
                if (pos < est)
                    est--;
            end
            else if (pick < 98)
            begin
                push_item(OP_REMOVE_VAL, pos, word);
                if (est > 0 && $urandom_range(1) == 1)
                    est--;
            end
            else
            begin
                push_item(OP_CLEAR, pos, word);
                est = 0;
            end
        end
    endtask

    // Builds the store up to its capacity with appends and shifting inserts,
    // then works at the full boundary. The last word written is a marker so
    // that a search can hit the top slot.
    task automatic build_fill(inout int est);
        int k;
        push_item(OP_CLEAR, 0, 32'd0);
        for (k = 0; k < MAX_ENTRIES - 1; k++)
        begin
            if ($urandom_range(1) == 1)
                push_item(OP_APPEND, $urandom_range(511), $urandom());
            else
                push_item(OP_INSERT, $urandom_range(k + 3), $urandom());
        end
        push_item(OP_APPEND, 0, MARKER);
        push_item(OP_APPEND, 3, 32'd1);
        push_item(OP_INSERT, 0, 32'd2);
        push_item(OP_GET, MAX_ENTRIES - 1, 32'd0);
        push_item(OP_FIND, 0, MARKER);
        push_item(OP_SET, MAX_ENTRIES - 1, 32'hFFFF_FFFF);
        push_item(OP_SET, MAX_ENTRIES - 1, MARKER);
        push_item(OP_REMOVE_VAL, 0, MARKER);
        push_item(OP_INSERT, 100, MARKER);
        push_item(OP_INSERT, 511, 32'd3);
        push_item(OP_GET, MAX_ENTRIES, 32'd0);
        push_item(OP_REMOVE_AT, MAX_ENTRIES - 1, 32'd0);
        est = MAX_ENTRIES - 1;
    endtask

    // Driver: offers the next transaction on the falling edge once the
    // current one has been taken, idling at a rate that depends on how far
    // the run has got. The last third runs with no idling at all.
    function automatic int idle_percent();
        if (sent_items * 3 < total_items)
            return 26;
        else if (sent_items * 3 < total_items * 2)
            return 51;
        return 0;
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || took)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= idle_percent())
            begin
                item <= pending_items.pop_front();
                start <= 1'b1;
                sent_items++;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: on each rising edge, check a strobed result against the
    // oldest expectation, then predict the transaction taken at this edge.
    // The result is checked first because a new transaction may be taken in
    // the same cycle that the previous result is strobed.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result strobed with no transaction outstanding");
                    error_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("value_out", oldest.value_out, result.value_out);
                    check_field("position_out", oldest.position_out, result.position_out);
                    check_field("found", oldest.found, result.found);
                    check_field("status", oldest.status, result.status);
                    check_field("count_out", oldest.count_out, result.count_out);
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_operation(item));
            took <= start && !busy;
        end
        else
        begin
            took <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int est;
        // Directed part: get, set, remove and search on an empty store, both
        // ends of an insert, a middle insert, out-of-range accesses, searches
        // that hit and miss, and a clear.
        push_item(OP_GET, 0, 32'd0);
        push_item(OP_REMOVE_AT, 0, 32'd0);
        push_item(OP_SET, 0, 32'd9);
        push_item(OP_FIND, 0, 32'd0);
        push_item(OP_REMOVE_VAL, 0, 32'd0);
        push_item(OP_APPEND, 511, 32'h7FFF_FFFF);
        push_item(OP_APPEND, 0, 32'h8000_0000);
        push_item(OP_INSERT, 0, 32'hFFFF_FFFF);
        push_item(OP_INSERT, 511, 32'd0);
        push_item(OP_INSERT, 2, 32'd5);
        push_item(OP_GET, 4, 32'd0);
        push_item(OP_GET, 0, 32'd0);
        push_item(OP_GET, 5, 32'd0);
        push_item(OP_SET, 1, 32'h1234_5678);
        push_item(OP_FIND, 0, 32'h8000_0000);
        push_item(OP_FIND, 0, 32'd99);
        push_item(OP_REMOVE_VAL, 0, 32'd5);
        push_item(OP_REMOVE_VAL, 0, 32'd77);
        push_item(OP_REMOVE_AT, 0, 32'd0);
        push_item(OP_REMOVE_AT, 256, 32'd0);
        push_item(OP_GET, 511, 32'd0);
        push_item(OP_CLEAR, 0, 32'd0);
        push_item(OP_GET, 0, 32'd0);
        push_item(OP_APPEND, 0, 32'd1);
        est = 1;

        build_mixed(400, est);
        build_fill(est);
        build_mixed(380, est);
        total_items = pending_items.size();

        // Wait until every transaction has been taken and answered, then let
        // the block run a little longer so a stray strobe would be caught.
        do
            @(posedge clk);
        while (pending_items.size() != 0 || start || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/core/isss_pkg.sv
rtl/core/isss_cell.sv
rtl/core/isss_prio_enc.sv
rtl/core/indexed_sequence_store_unit.sv
test/testbench.sv
